// File: rtl/arke_pkg.sv
`timescale 1ns / 1ps

package arke_pkg;

  localparam int unsigned PcW = 7;

  localparam logic signed [63:0] LimV      = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] LimQ      = 64'sh0FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] LimV65    = 65'sh0_3FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] RatioLo   = 64'sd536870912;
  localparam logic signed [63:0] RatioHi   = 64'sd1073741824;
  localparam logic signed [63:0] CovWind   = 64'sh64_0000_0000;
  localparam logic signed [63:0] CovRatio  = 64'sd4295;
  localparam logic signed [63:0] HspdMinSq = 64'sd4295;

  localparam logic [32:0] WindNoiseRst  = 33'd42949673;
  localparam logic [32:0] RatioNoiseRst = 33'd2147;
  localparam logic [35:0] MeasNoiseRst  = 36'h1_0000_0000;
  localparam logic [22:0] WindLimitRst  = 23'd1441792;
  localparam logic [16:0] InitRatioRst  = 17'd65536;

  typedef enum logic [2:0] {
    CFG_WNOISE = 3'd0,
    CFG_RNOISE = 3'd1,
    CFG_MNOISE = 3'd2,
    CFG_WLIM   = 3'd3,
    CFG_RINIT  = 3'd4
  } cfg_e;

  typedef enum logic [4:0] {
    OP_LDI, OP_ADD, OP_SUB, OP_NEG, OP_AVG, OP_AVGF, OP_WADD, OP_RADD, OP_R16,
    OP_MUL, OP_DIV, OP_SQRT, OP_JINIT, OP_JRLD, OP_JHS, OP_JNP, OP_SETUPD, OP_DONE
  } op_e;

  typedef enum logic [4:0] {
    R_P0, R_P1, R_P2, R_P3, R_P4, R_P5, R_WN, R_WE, R_RT, R_DN, R_DE, R_DD,
    R_MEAS, R_H0, R_H1, R_H2, R_F0, R_F1, R_F2, R_K0, R_K1, R_K2, R_S,
    R_T0, R_T1, R_T2, R_R16, R_PRED, R_ERR
  } reg_e;

  typedef enum logic [3:0] {
    SRC_ZERO, SRC_CWIND, SRC_CRATIO, SRC_WNOISE, SRC_RNOISE, SRC_MNOISE,
    SRC_RINIT, SRC_MEAS, SRC_VN, SRC_VE, SRC_VD
  } src_e;

  typedef enum logic [1:0] {SH_0, SH_16, SH_18, SH_32} shift_e;

  typedef struct packed {
    op_e            op;
    reg_e           dst;
    reg_e           ra;
    reg_e           rb;
    shift_e         sh;
    src_e           src;
    logic [PcW-1:0] tgt;
  } uword_t;

  localparam logic [PcW-1:0] PcBody  = 7'd9;
  localparam logic [PcW-1:0] PcNoise = 7'd11;
  localparam logic [PcW-1:0] PcDone  = 7'd96;

  function automatic logic [63:0] mag(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic signed [63:0] sat64(input logic signed [64:0] v);
    logic signed [63:0] r;
    if (v > LimV65) r = LimV;
    else if (v < -LimV65) r = -LimV;
    else r = v[63:0];
    return r;
  endfunction

  function automatic logic signed [63:0] clampq(input logic signed [63:0] v);
    logic signed [63:0] r;
    if (v > LimQ) r = LimQ;
    else if (v < -LimQ) r = -LimQ;
    else r = v;
    return r;
  endfunction

  function automatic uword_t u_w(op_e op, reg_e dst, reg_e ra, reg_e rb, shift_e sh,
                                 src_e src, logic [PcW-1:0] tgt);
    uword_t w;
    w.op  = op;
    w.dst = dst;
    w.ra  = ra;
    w.rb  = rb;
    w.sh  = sh;
    w.src = src;
    w.tgt = tgt;
    return w;
  endfunction

  function automatic uword_t u_ldi(reg_e dst, src_e src);
    return u_w(OP_LDI, dst, R_T0, R_T0, SH_0, src, '0);
  endfunction

  function automatic uword_t u_alu(op_e op, reg_e dst, reg_e ra, reg_e rb);
    return u_w(op, dst, ra, rb, SH_0, SRC_ZERO, '0);
  endfunction

  function automatic uword_t u_mul(op_e op, reg_e dst, reg_e ra, reg_e rb, shift_e sh);
    return u_w(op, dst, ra, rb, sh, SRC_ZERO, '0);
  endfunction

  function automatic uword_t u_jmp(op_e op, reg_e ra, logic [PcW-1:0] tgt);
    return u_w(op, R_T0, ra, ra, SH_0, SRC_ZERO, tgt);
  endfunction

  function automatic uword_t u_ctl(op_e op);
    return u_w(op, R_T0, R_T0, R_T0, SH_0, SRC_ZERO, '0);
  endfunction

  // filter program; covariance entries are updated in place since each new
  // entry depends only on its own old value, the gains and F
  function automatic uword_t ucode_rom(input logic [PcW-1:0] pc);
    uword_t w;
    case (pc)
      7'd0:  w = u_jmp(OP_JINIT, R_T0, PcBody);
      7'd1:  w = u_ldi(R_P0, SRC_CWIND);
      7'd2:  w = u_ldi(R_P1, SRC_ZERO);
      7'd3:  w = u_ldi(R_P2, SRC_ZERO);
      7'd4:  w = u_ldi(R_P3, SRC_CWIND);
      7'd5:  w = u_ldi(R_P4, SRC_ZERO);
      7'd6:  w = u_ldi(R_P5, SRC_CRATIO);
      7'd7:  w = u_ldi(R_WN, SRC_ZERO);
      7'd8:  w = u_ldi(R_WE, SRC_ZERO);
      7'd9:  w = u_jmp(OP_JRLD, R_T0, PcNoise);
      7'd10: w = u_ldi(R_RT, SRC_RINIT);
      7'd11: w = u_ldi(R_T0, SRC_WNOISE);
      7'd12: w = u_alu(OP_ADD, R_P0, R_P0, R_T0);
      7'd13: w = u_alu(OP_ADD, R_P3, R_P3, R_T0);
      7'd14: w = u_ldi(R_T0, SRC_RNOISE);
      7'd15: w = u_alu(OP_ADD, R_P5, R_P5, R_T0);
      7'd16: w = u_ldi(R_T0, SRC_VN);
      7'd17: w = u_alu(OP_SUB, R_DN, R_T0, R_WN);
      7'd18: w = u_ldi(R_T0, SRC_VE);
      7'd19: w = u_alu(OP_SUB, R_DE, R_T0, R_WE);
      7'd20: w = u_ldi(R_DD, SRC_VD);
      7'd21: w = u_ldi(R_MEAS, SRC_MEAS);
      7'd22: w = u_alu(OP_R16, R_R16, R_RT, R_RT);
      7'd23: w = u_mul(OP_MUL, R_T0, R_DN, R_DN, SH_0);
      7'd24: w = u_mul(OP_MUL, R_T1, R_DE, R_DE, SH_0);
      7'd25: w = u_alu(OP_ADD, R_T0, R_T0, R_T1);
      7'd26: w = u_jmp(OP_JHS, R_T0, PcDone);
      7'd27: w = u_mul(OP_SQRT, R_H2, R_T0, R_T0, SH_0);
      7'd28: w = u_mul(OP_MUL, R_T1, R_DD, R_DD, SH_0);
      7'd29: w = u_alu(OP_ADD, R_T1, R_T0, R_T1);
      7'd30: w = u_mul(OP_SQRT, R_T1, R_T1, R_T1, SH_0);
      7'd31: w = u_mul(OP_MUL, R_PRED, R_R16, R_T1, SH_16);
      7'd32: w = u_mul(OP_MUL, R_T0, R_R16, R_DN, SH_0);
      7'd33: w = u_mul(OP_DIV, R_T0, R_T0, R_H2, SH_0);
      7'd34: w = u_alu(OP_NEG, R_H0, R_T0, R_T0);
      7'd35: w = u_mul(OP_MUL, R_T0, R_R16, R_DE, SH_0);
      7'd36: w = u_mul(OP_DIV, R_T0, R_T0, R_H2, SH_0);
      7'd37: w = u_alu(OP_NEG, R_H1, R_T0, R_T0);
      7'd38: w = u_mul(OP_MUL, R_F0, R_P0, R_H0, SH_16);
      7'd39: w = u_mul(OP_MUL, R_T0, R_P1, R_H1, SH_16);
      7'd40: w = u_alu(OP_ADD, R_F0, R_F0, R_T0);
      7'd41: w = u_mul(OP_MUL, R_T0, R_P2, R_H2, SH_16);
      7'd42: w = u_alu(OP_ADD, R_F0, R_F0, R_T0);
      7'd43: w = u_mul(OP_MUL, R_F1, R_P1, R_H0, SH_16);
      7'd44: w = u_mul(OP_MUL, R_T0, R_P3, R_H1, SH_16);
      7'd45: w = u_alu(OP_ADD, R_F1, R_F1, R_T0);
      7'd46: w = u_mul(OP_MUL, R_T0, R_P4, R_H2, SH_16);
      7'd47: w = u_alu(OP_ADD, R_F1, R_F1, R_T0);
      7'd48: w = u_mul(OP_MUL, R_F2, R_P2, R_H0, SH_16);
      7'd49: w = u_mul(OP_MUL, R_T0, R_P4, R_H1, SH_16);
      7'd50: w = u_alu(OP_ADD, R_F2, R_F2, R_T0);
      7'd51: w = u_mul(OP_MUL, R_T0, R_P5, R_H2, SH_16);
      7'd52: w = u_alu(OP_ADD, R_F2, R_F2, R_T0);
      7'd53: w = u_ldi(R_S, SRC_MNOISE);
      7'd54: w = u_mul(OP_MUL, R_T0, R_H0, R_F0, SH_16);
      7'd55: w = u_alu(OP_ADD, R_S, R_S, R_T0);
      7'd56: w = u_mul(OP_MUL, R_T0, R_H1, R_F1, SH_16);
      7'd57: w = u_alu(OP_ADD, R_S, R_S, R_T0);
      7'd58: w = u_mul(OP_MUL, R_T0, R_H2, R_F2, SH_16);
      7'd59: w = u_alu(OP_ADD, R_S, R_S, R_T0);
      7'd60: w = u_jmp(OP_JNP, R_S, PcDone);
      7'd61: w = u_ctl(OP_SETUPD);
      7'd62: w = u_mul(OP_DIV, R_K0, R_F0, R_S, SH_32);
      7'd63: w = u_mul(OP_DIV, R_K1, R_F1, R_S, SH_32);
      7'd64: w = u_mul(OP_DIV, R_K2, R_F2, R_S, SH_32);
      7'd65: w = u_alu(OP_SUB, R_ERR, R_MEAS, R_PRED);
      7'd66: w = u_mul(OP_MUL, R_T0, R_K0, R_ERR, SH_32);
      7'd67: w = u_alu(OP_WADD, R_WN, R_WN, R_T0);
      7'd68: w = u_mul(OP_MUL, R_T0, R_K1, R_ERR, SH_32);
      7'd69: w = u_alu(OP_WADD, R_WE, R_WE, R_T0);
      7'd70: w = u_mul(OP_MUL, R_T0, R_K2, R_ERR, SH_18);
      7'd71: w = u_alu(OP_RADD, R_RT, R_RT, R_T0);
      7'd72: w = u_mul(OP_MUL, R_T0, R_K0, R_F0, SH_32);
      7'd73: w = u_alu(OP_SUB, R_T1, R_P0, R_T0);
      7'd74: w = u_alu(OP_AVGF, R_P0, R_T1, R_T1);
      7'd75: w = u_mul(OP_MUL, R_T0, R_K0, R_F1, SH_32);
      7'd76: w = u_alu(OP_SUB, R_T1, R_P1, R_T0);
      7'd77: w = u_mul(OP_MUL, R_T0, R_K1, R_F0, SH_32);
      7'd78: w = u_alu(OP_SUB, R_T2, R_P1, R_T0);
      7'd79: w = u_alu(OP_AVG, R_P1, R_T1, R_T2);
      7'd80: w = u_mul(OP_MUL, R_T0, R_K0, R_F2, SH_32);
      7'd81: w = u_alu(OP_SUB, R_T1, R_P2, R_T0);
      7'd82: w = u_mul(OP_MUL, R_T0, R_K2, R_F0, SH_32);
      7'd83: w = u_alu(OP_SUB, R_T2, R_P2, R_T0);
      7'd84: w = u_alu(OP_AVG, R_P2, R_T1, R_T2);
      7'd85: w = u_mul(OP_MUL, R_T0, R_K1, R_F1, SH_32);
      7'd86: w = u_alu(OP_SUB, R_T1, R_P3, R_T0);
      7'd87: w = u_alu(OP_AVGF, R_P3, R_T1, R_T1);
      7'd88: w = u_mul(OP_MUL, R_T0, R_K1, R_F2, SH_32);
      7'd89: w = u_alu(OP_SUB, R_T1, R_P4, R_T0);
      7'd90: w = u_mul(OP_MUL, R_T0, R_K2, R_F1, SH_32);
      7'd91: w = u_alu(OP_SUB, R_T2, R_P4, R_T0);
      7'd92: w = u_alu(OP_AVG, R_P4, R_T1, R_T2);
      7'd93: w = u_mul(OP_MUL, R_T0, R_K2, R_F2, SH_32);
      7'd94: w = u_alu(OP_SUB, R_T1, R_P5, R_T0);
      7'd95: w = u_alu(OP_AVGF, R_P5, R_T1, R_T1);
      default: w = u_ctl(OP_DONE);
    endcase
    return w;
  endfunction

endpackage

// File: rtl/airspeed_ratio_kalman_estimator.sv
`timescale 1ns / 1ps

// Three-state EKF for wind (north, east) and airspeed ratio, one result beat
// per input beat. A small program in a ROM drives a 64-bit register file, a
// multiplier that sums four 32x32 partial products (one per cycle), a
// restoring divider (one quotient bit per cycle) and a floor square root (two
// radicand bits per cycle). In a full correction the five divides dominate
// the run time. The program skips the correction for tiny horizontal speed
// and for non-positive innovation variance. The next input beat can be taken
// in the cycle after the result is loaded. The first beat after reset also
// runs 8 init steps that load the covariance and wind state. That beat, and
// the first beat after an initial_ratio write, also runs a ratio load step.
// One item is in work at a time; the output register lets a new input beat in
// while the previous result still waits.
module airspeed_ratio_kalman_estimator (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [35:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [22:0]        measured_airspeed_i,
  input  logic signed [23:0] ground_vel_north_i,
  input  logic signed [23:0] ground_vel_east_i,
  input  logic signed [23:0] ground_vel_down_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [16:0]        ratio_estimate_o,
  output logic signed [23:0] wind_north_out_o,
  output logic signed [23:0] wind_east_out_o,
  output logic               was_updated_o
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_READ = 5'b00010,
    ST_LOAD = 5'b00100,
    ST_RUN  = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [arke_pkg::PcW-1:0] pc_q, pc_d;
  logic [6:0] cnt_q, cnt_d;
  arke_pkg::uword_t uw;

  logic [32:0] wnoise_q, rnoise_q;
  logic [35:0] mnoise_q;
  logic [22:0] wlim_q;
  logic [16:0] rinit_q;
  logic init_done_q, rld_q, upd_q;

  logic [22:0] meas_q;
  logic signed [23:0] vn_q, ve_q, vd_q;

  logic signed [63:0] rf_q [32];
  logic signed [63:0] a_q, b_q;
  logic signed [23:0] wn_sh_q, we_sh_q;
  logic [16:0] rt_sh_q;

  logic out_valid_q, upd_out_q;
  logic [16:0] ratio_q;
  logic signed [23:0] wno_q, weo_q;

  logic [63:0] m_a_q, m_b_q;
  logic m_neg_q;
  logic [127:0] acc_q;
  logic [95:0] d_num_q;
  logic [64:0] d_rem_q;
  logic [63:0] d_quo_q;
  logic d_ovf_q;
  logic [63:0] s_x_q, s_res_q, s_bit_q;

  logic wr_en;
  logic signed [63:0] wr_data, alu_res, imm, unit_res;
  logic in_acc, out_load;

  logic [31:0] mx, my;
  logic [63:0] pp;
  logic [127:0] addend, shifted;
  logic [63:0] mres, qres;
  logic [64:0] r2, rsub;
  logic ge;
  logic [63:0] st;
  logic s_ge;

  logic signed [64:0] sum65, diff65, avg65, wsum, lim65;
  logic signed [63:0] avg64;
  logic [30:0] rinit_sh;
  logic [63:0] rinit_cl;
  logic unit_last;

  assign uw = arke_pkg::ucode_rom(pc_q);
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc = in_valid_i && in_ready_o;
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  // immediate sources
  always_comb begin
    rinit_sh = {rinit_q, 14'b0};
    if ({33'b0, rinit_sh} < 64'(arke_pkg::RatioLo)) rinit_cl = 64'(arke_pkg::RatioLo);
    else if ({33'b0, rinit_sh} > 64'(arke_pkg::RatioHi)) rinit_cl = 64'(arke_pkg::RatioHi);
    else rinit_cl = {33'b0, rinit_sh};
    case (uw.src)
      arke_pkg::SRC_ZERO:   imm = '0;
      arke_pkg::SRC_CWIND:  imm = arke_pkg::CovWind;
      arke_pkg::SRC_CRATIO: imm = arke_pkg::CovRatio;
      arke_pkg::SRC_WNOISE: imm = $signed({31'b0, wnoise_q});
      arke_pkg::SRC_RNOISE: imm = $signed({31'b0, rnoise_q});
      arke_pkg::SRC_MNOISE: imm = $signed({28'b0, mnoise_q});
      arke_pkg::SRC_RINIT:  imm = $signed(rinit_cl);
      arke_pkg::SRC_MEAS:   imm = $signed({41'b0, meas_q});
      arke_pkg::SRC_VN:     imm = 64'(vn_q);
      arke_pkg::SRC_VE:     imm = 64'(ve_q);
      arke_pkg::SRC_VD:     imm = 64'(vd_q);
      default:              imm = '0;
    endcase
  end

  // combinational ALU operations
  always_comb begin
    sum65  = 65'(a_q) + 65'(b_q);
    diff65 = 65'(a_q) - 65'(b_q);
    avg65  = (sum65 + (sum65[64] ? 65'sd1 : 65'sd0)) >>> 1;
    avg64  = avg65[63:0];
    wsum   = 65'(a_q) + 65'(arke_pkg::clampq(b_q));
    lim65  = $signed({42'b0, wlim_q});
    case (uw.op)
      arke_pkg::OP_LDI:  alu_res = imm;
      arke_pkg::OP_ADD:  alu_res = arke_pkg::sat64(sum65);
      arke_pkg::OP_SUB:  alu_res = arke_pkg::sat64(diff65);
      arke_pkg::OP_NEG:  alu_res = arke_pkg::sat64(-65'(a_q));
      arke_pkg::OP_AVG:  alu_res = avg64;
      arke_pkg::OP_AVGF: alu_res = avg64[63] ? 64'sd0 : avg64;
      arke_pkg::OP_WADD: begin
        if (wsum > lim65) alu_res = lim65[63:0];
        else if (wsum < -lim65) alu_res = 64'(-lim65);
        else alu_res = wsum[63:0];
      end
      arke_pkg::OP_RADD: begin
        if (wsum > 65'(arke_pkg::RatioHi)) alu_res = arke_pkg::RatioHi;
        else if (wsum < 65'(arke_pkg::RatioLo)) alu_res = arke_pkg::RatioLo;
        else alu_res = wsum[63:0];
      end
      arke_pkg::OP_R16:  alu_res = a_q >>> 14;
      default:           alu_res = '0;
    endcase
  end

  // multi-cycle units: step logic and final results
  always_comb begin
    case (cnt_q[1:0])
      2'd0: begin mx = m_a_q[31:0];  my = m_b_q[31:0];  end
      2'd1: begin mx = m_a_q[31:0];  my = m_b_q[63:32]; end
      2'd2: begin mx = m_a_q[63:32]; my = m_b_q[31:0];  end
      default: begin mx = m_a_q[63:32]; my = m_b_q[63:32]; end
    endcase
    pp = 64'(mx) * 64'(my);
    case (cnt_q[1:0])
      2'd0:    addend = {64'b0, pp};
      2'd1:    addend = {32'b0, pp, 32'b0};
      2'd2:    addend = {32'b0, pp, 32'b0};
      default: addend = {pp, 64'b0};
    endcase
    case (uw.sh)
      arke_pkg::SH_0:  shifted = acc_q;
      arke_pkg::SH_16: shifted = acc_q >> 16;
      arke_pkg::SH_18: shifted = acc_q >> 18;
      default:         shifted = acc_q >> 32;
    endcase
    mres = (shifted > {64'b0, 64'(arke_pkg::LimV)}) ? 64'(arke_pkg::LimV) : shifted[63:0];

    r2   = {d_rem_q[63:0], d_num_q[95]};
    ge   = (r2 >= {1'b0, 64'(b_q)});
    rsub = r2 - {1'b0, 64'(b_q)};
    qres = d_ovf_q ? 64'(arke_pkg::LimV) : d_quo_q;

    st   = s_res_q + s_bit_q;
    s_ge = (s_x_q >= st);

    case (uw.op)
      arke_pkg::OP_MUL: begin
        unit_res  = m_neg_q ? -$signed(mres) : $signed(mres);
        unit_last = (cnt_q == 7'd4);
      end
      arke_pkg::OP_DIV: begin
        unit_res  = m_neg_q ? -$signed(qres) : $signed(qres);
        unit_last = (cnt_q == 7'd96);
      end
      default: begin
        unit_res  = $signed(s_res_q);
        unit_last = (cnt_q == 7'd32);
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    cnt_d   = cnt_q;
    wr_en   = 1'b0;
    wr_data = alu_res;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_READ;
          pc_d    = '0;
        end
      end
      ST_READ: state_d = ST_LOAD;
      ST_LOAD: begin
        state_d = ST_READ;
        pc_d    = pc_q + 1'b1;
        case (uw.op)
          arke_pkg::OP_MUL, arke_pkg::OP_DIV, arke_pkg::OP_SQRT: begin
            state_d = ST_RUN;
            pc_d    = pc_q;
            cnt_d   = '0;
          end
          arke_pkg::OP_JINIT: if (init_done_q) pc_d = uw.tgt;
          arke_pkg::OP_JRLD:  if (!rld_q) pc_d = uw.tgt;
          arke_pkg::OP_JHS:   if (a_q < arke_pkg::HspdMinSq) pc_d = uw.tgt;
          arke_pkg::OP_JNP:   if (a_q <= 64'sd0) pc_d = uw.tgt;
          arke_pkg::OP_SETUPD: ;
          arke_pkg::OP_DONE: begin
            state_d = ST_DONE;
            pc_d    = pc_q;
          end
          default: wr_en = 1'b1;
        endcase
      end
      ST_RUN: begin
        cnt_d = cnt_q + 1'b1;
        if (unit_last) begin
          wr_en   = 1'b1;
          wr_data = unit_res;
          pc_d    = pc_q + 1'b1;
          state_d = ST_READ;
        end
      end
      ST_DONE: if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pc_q        <= '0;
      cnt_q       <= '0;
      wnoise_q    <= arke_pkg::WindNoiseRst;
      rnoise_q    <= arke_pkg::RatioNoiseRst;
      mnoise_q    <= arke_pkg::MeasNoiseRst;
      wlim_q      <= arke_pkg::WindLimitRst;
      rinit_q     <= arke_pkg::InitRatioRst;
      init_done_q <= 1'b0;
      rld_q       <= 1'b1;
      upd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          arke_pkg::CFG_WNOISE: wnoise_q <= cfg_wdata_i[32:0];
          arke_pkg::CFG_RNOISE: rnoise_q <= cfg_wdata_i[32:0];
          arke_pkg::CFG_MNOISE: mnoise_q <= cfg_wdata_i;
          arke_pkg::CFG_WLIM:   wlim_q   <= cfg_wdata_i[22:0];
          arke_pkg::CFG_RINIT: begin
            rinit_q <= cfg_wdata_i[16:0];
            rld_q   <= 1'b1;
          end
          default: ;
        endcase
      end
      if (in_acc) upd_q <= 1'b0;
      if (state_q == ST_LOAD) begin
        case (uw.op)
          arke_pkg::OP_JINIT:  init_done_q <= 1'b1;
          arke_pkg::OP_JRLD:   rld_q <= 1'b0;
          arke_pkg::OP_SETUPD: upd_q <= 1'b1;
          default: ;
        endcase
      end
      out_valid_q <= out_load || (out_valid_q && !out_ready_i);
    end
  end

  // datapath, register file and result register
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      meas_q <= measured_airspeed_i;
      vn_q   <= ground_vel_north_i;
      ve_q   <= ground_vel_east_i;
      vd_q   <= ground_vel_down_i;
    end
    if (state_q == ST_READ) begin
      a_q <= rf_q[uw.ra];
      b_q <= rf_q[uw.rb];
    end
    if (wr_en) begin
      rf_q[uw.dst] <= wr_data;
      if (uw.dst == arke_pkg::R_WN) wn_sh_q <= wr_data[23:0];
      if (uw.dst == arke_pkg::R_WE) we_sh_q <= wr_data[23:0];
      if (uw.dst == arke_pkg::R_RT) rt_sh_q <= wr_data[30:14];
    end
    if (state_q == ST_LOAD) begin
      m_a_q   <= arke_pkg::mag(a_q);
      m_b_q   <= arke_pkg::mag(b_q);
      m_neg_q <= (uw.op == arke_pkg::OP_MUL) ? (a_q[63] ^ b_q[63]) : a_q[63];
      acc_q   <= '0;
      d_num_q <= (uw.sh == arke_pkg::SH_32) ? {arke_pkg::mag(a_q), 32'b0}
                                            : {32'b0, arke_pkg::mag(a_q)};
      d_rem_q <= '0;
      d_quo_q <= '0;
      d_ovf_q <= 1'b0;
      s_x_q   <= a_q;
      s_res_q <= '0;
      s_bit_q <= 64'h4000_0000_0000_0000;
    end
    if ((state_q == ST_RUN) && !unit_last) begin
      case (uw.op)
        arke_pkg::OP_MUL: acc_q <= acc_q + addend;
        arke_pkg::OP_DIV: begin
          d_num_q <= {d_num_q[94:0], 1'b0};
          d_rem_q <= ge ? rsub : r2;
          d_quo_q <= {d_quo_q[62:0], ge};
          // quotient bits 62 and up saturate
          if (ge && (cnt_q <= 7'd33)) d_ovf_q <= 1'b1;
        end
        default: begin
          if (s_ge) begin
            s_x_q   <= s_x_q - st;
            s_res_q <= (s_res_q >> 1) + s_bit_q;
          end else begin
            s_res_q <= s_res_q >> 1;
          end
          s_bit_q <= s_bit_q >> 2;
        end
      endcase
    end
    if (out_load) begin
      ratio_q   <= rt_sh_q;
      wno_q     <= wn_sh_q;
      weo_q     <= we_sh_q;
      upd_out_q <= upd_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign ratio_estimate_o = ratio_q;
  assign wind_north_out_o = wno_q;
  assign wind_east_out_o  = weo_q;
  assign was_updated_o    = upd_out_q;

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam longint unsigned CycleLimit = 64'd40_000_000;
  localparam logic signed [63:0] LimQuarter = arke_pkg::LimV / 4;

  typedef struct {
    logic [22:0]        meas;
    logic signed [23:0] vn;
    logic signed [23:0] ve;
    logic signed [23:0] vd;
  } gps_beat_t;

  typedef struct {
    logic [16:0]        ratio;
    logic signed [23:0] wn;
    logic signed [23:0] we;
    logic               upd;
  } est_beat_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_index_i = '0;
  logic [35:0]        cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [22:0]        measured_airspeed_i = '0;
  logic signed [23:0] ground_vel_north_i = '0;
  logic signed [23:0] ground_vel_east_i = '0;
  logic signed [23:0] ground_vel_down_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [16:0]        ratio_estimate_o;
  logic signed [23:0] wind_north_out_o;
  logic signed [23:0] wind_east_out_o;
  logic               was_updated_o;

  airspeed_ratio_kalman_estimator u_top (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // filter state mirror
  logic [32:0]        m_wnoise, m_rnoise;
  logic [35:0]        m_mnoise;
  logic [22:0]        m_wlim;
  logic [16:0]        m_rinit;
  logic signed [63:0] m_wn, m_we, m_rt;
  logic signed [63:0] m_cov [6];

  gps_beat_t gps_q[$];
  est_beat_t est_q[$];
  gps_beat_t gps_cur;
  bit        gps_taken = 0;
  int        src_idle = 0, snk_idle = 0;
  int        mismatches = 0, results_seen = 0, updates_seen = 0;
  longint    cycles = 0;

  function automatic logic signed [63:0] clampv(logic signed [63:0] v, lo, hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic logic signed [63:0] sadd(logic signed [63:0] a, b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s > 65'sd0 + arke_pkg::LimV) return arke_pkg::LimV;
    if (s < -(65'sd0 + arke_pkg::LimV)) return -arke_pkg::LimV;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] mul_q(logic signed [63:0] a, b, int sh);
    logic [127:0] p;
    logic [63:0]  ua, ub, r;
    ua = a[63] ? -a : a;
    ub = b[63] ? -b : b;
    p = ({64'd0, ua} * {64'd0, ub}) >> sh;
    r = (p > {64'd0, arke_pkg::LimV}) ? arke_pkg::LimV : p[63:0];
    return (a[63] ^ b[63]) ? -r : r;
  endfunction

  function automatic logic signed [63:0] div_q(logic signed [63:0] num, den, int sh);
    logic [127:0] p;
    logic [63:0]  un, r;
    un = num[63] ? -num : num;
    p = ({64'd0, un} << sh) / {64'd0, den};
    r = (p >= (128'd1 << 62)) ? arke_pkg::LimV : p[63:0];
    return num[63] ? -r : r;
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [63:0] x);
    logic [63:0] res, bv;
    res = '0;
    bv = 64'd1 << 62;
    while (bv > x) bv >>= 2;
    while (bv != 0) begin
      if (x >= res + bv) begin
        x = x - (res + bv);
        res = (res >> 1) + bv;
      end else begin
        res >>= 1;
      end
      bv >>= 2;
    end
    return res;
  endfunction

  function automatic int cov_at(int i, int j);
    int lo, hi;
    lo = i < j ? i : j;
    hi = i < j ? j : i;
    if (lo == 0) return hi;
    if (lo == 1) return hi + 2;
    return 5;
  endfunction

  task automatic filter_reset();
    m_wnoise = arke_pkg::WindNoiseRst;
    m_rnoise = arke_pkg::RatioNoiseRst;
    m_mnoise = arke_pkg::MeasNoiseRst;
    m_wlim   = arke_pkg::WindLimitRst;
    m_rinit  = arke_pkg::InitRatioRst;
    m_wn = '0;
    m_we = '0;
    m_rt = 64'(m_rinit) << 14;
    m_cov[0] = arke_pkg::CovWind;
    m_cov[1] = '0;
    m_cov[2] = '0;
    m_cov[3] = arke_pkg::CovWind;
    m_cov[4] = '0;
    m_cov[5] = arke_pkg::CovRatio;
  endtask

  task automatic filter_step(gps_beat_t g);
    logic signed [63:0] meas, dn, de, dd, r16, hn, pred, s, err, lim, p, a, b, v;
    logic signed [63:0] h [3];
    logic signed [63:0] f [3];
    logic signed [63:0] k [3];
    logic signed [63:0] np [6];
    logic [63:0]        h2;
    est_beat_t          e;
    meas = 64'(g.meas);
    dn = 64'(g.vn) - m_wn;
    de = 64'(g.ve) - m_we;
    dd = 64'(g.vd);
    r16 = m_rt >>> 14;
    e.upd = 1'b0;
    m_cov[0] = sadd(m_cov[0], 64'(m_wnoise));
    m_cov[3] = sadd(m_cov[3], 64'(m_wnoise));
    m_cov[5] = sadd(m_cov[5], 64'(m_rnoise));
    h2 = dn * dn + de * de;
    if (h2 >= arke_pkg::HspdMinSq) begin
      hn = floor_sqrt(h2);
      pred = (r16 * floor_sqrt(h2 + dd * dd)) >> 16;
      h[0] = -((r16 * dn) / hn);
      h[1] = -((r16 * de) / hn);
      h[2] = hn;
      for (int i = 0; i < 3; i++) begin
        f[i] = '0;
        for (int j = 0; j < 3; j++) f[i] = sadd(f[i], mul_q(m_cov[cov_at(i, j)], h[j], 16));
      end
      s = 64'(m_mnoise);
      for (int i = 0; i < 3; i++) s = sadd(s, mul_q(h[i], f[i], 16));
      if (s > 0) begin
        e.upd = 1'b1;
        for (int i = 0; i < 3; i++) k[i] = div_q(f[i], s, 32);
        err = meas - pred;
        lim = 64'(m_wlim);
        m_wn = clampv(m_wn + clampv(mul_q(k[0], err, 32), -LimQuarter, LimQuarter), -lim, lim);
        m_we = clampv(m_we + clampv(mul_q(k[1], err, 32), -LimQuarter, LimQuarter), -lim, lim);
        m_rt = clampv(m_rt + clampv(mul_q(k[2], err, 18), -LimQuarter, LimQuarter),
                      arke_pkg::RatioLo, arke_pkg::RatioHi);
        for (int i = 0; i < 3; i++) begin
          for (int j = i; j < 3; j++) begin
            p = m_cov[cov_at(i, j)];
            a = sadd(p, -mul_q(k[i], f[j], 32));
            b = sadd(p, -mul_q(k[j], f[i], 32));
            v = (a + b) / 2;
            if (i == j && v < 0) v = '0;
            np[cov_at(i, j)] = v;
          end
        end
        for (int i = 0; i < 6; i++) m_cov[i] = np[i];
      end
    end
    e.ratio = 17'(m_rt >>> 14);
    e.wn = m_wn[23:0];
    e.we = m_we[23:0];
    est_q.push_back(e);
  endtask

  task automatic cfg_write(arke_pkg::cfg_e idx, logic [35:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      arke_pkg::CFG_WNOISE: m_wnoise = data[32:0];
      arke_pkg::CFG_RNOISE: m_rnoise = data[32:0];
      arke_pkg::CFG_MNOISE: m_mnoise = data;
      arke_pkg::CFG_WLIM:   m_wlim = data[22:0];
      arke_pkg::CFG_RINIT: begin
        m_rinit = data[16:0];
        m_rt = clampv(64'(m_rinit) << 14, arke_pkg::RatioLo, arke_pkg::RatioHi);
      end
      default: ;
    endcase
  endtask

  task automatic add_beat(logic [22:0] meas, logic signed [23:0] vn, ve, vd);
    gps_beat_t g;
    g.meas = meas;
    g.vn = vn;
    g.ve = ve;
    g.vd = vd;
    gps_q.push_back(g);
  endtask

  // mostly plausible flight: airspeed and ground velocity in flight ranges, some noise
  task automatic add_random(int n);
    int sel;
    logic signed [23:0] vn, ve;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      if (sel < 8) begin
        add_beat(23'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
      end else if (sel < 13) begin
        add_beat(23'($urandom_range(0, 30 << 16)), m_wn[23:0] + 24'($urandom_range(0, 1)),
                 m_we[23:0], 24'(int'($urandom_range(0, 40000)) - 20000));
      end else begin
        vn = 24'(int'($urandom_range(0, 60 << 16)) - (30 << 16));
        ve = 24'(int'($urandom_range(0, 60 << 16)) - (30 << 16));
        add_beat(23'($urandom_range(5 << 16, 40 << 16)), vn, ve,
                 24'(int'($urandom_range(0, 10 << 16)) - (5 << 16)));
      end
    end
  endtask

  task automatic drain();
    wait (gps_q.size() == 0 && !in_valid_i && est_q.size() == 0);
    repeat (40) @(posedge clk_i);
  endtask

  // driver: a new beat may be offered once the previous one was taken
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      filter_step(gps_cur);
      gps_taken = 1;
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= snk_idle);
    if (!in_valid_i || gps_taken) begin
      gps_taken = 0;
      if (rst_ni && gps_q.size() != 0 && $urandom_range(99) >= src_idle) begin
        gps_cur = gps_q.pop_front();
        in_valid_i <= 1'b1;
        measured_airspeed_i <= gps_cur.meas;
        ground_vel_north_i <= gps_cur.vn;
        ground_vel_east_i <= gps_cur.ve;
        ground_vel_down_i <= gps_cur.vd;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    est_beat_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (was_updated_o) updates_seen++;
      if (est_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat at cycle %0d", cycles);
      end else begin
        e = est_q.pop_front();
        if (e.ratio !== ratio_estimate_o || e.wn !== wind_north_out_o ||
            e.we !== wind_east_out_o || e.upd !== was_updated_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch beat %0d: exp ratio %0d wn %0d we %0d upd %0b, got %0d %0d %0d %0b",
                     results_seen, e.ratio, e.wn, e.we, e.upd, ratio_estimate_o,
                     wind_north_out_o, wind_east_out_o, was_updated_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout with %0d results pending", est_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    filter_reset();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // phase 0: defaults first, sender 31% idle, receiver 80%
    src_idle = 31;
    snk_idle = 80;
    add_beat('0, '0, '0, '0);
    add_beat(23'h7FFFFF, 24'sd6553600, 24'sd6553600, 24'sd6553600);
    add_beat('0, -24'sd6553600, -24'sd6553600, -24'sd6553600);
    add_beat(23'd6553600, 24'sd6553600, -24'sd6553600, '0);
    add_beat(23'(20 << 16), 24'sd1, '0, '0);
    add_beat(23'(20 << 16), 24'sd66, '0, '0);
    add_beat(23'(20 << 16), 24'sd1 << 16, 24'sd1 << 16, 24'sd2000 << 8);
    add_beat(23'h7FFFFF, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF);
    add_beat('0, 24'sh800000, 24'sh7FFFFF, 24'sh800000);
    add_beat(23'(15 << 16), 24'sd15 << 16, '0, '0);
    add_beat(23'(15 << 16), '0, 24'sd15 << 16, '0);
    add_beat(23'(30 << 16), -24'sd20 << 16, 24'sd10 << 16, -24'sd3 << 16);
    add_random(430);
    drain();

    // phase 1: extremes of noise and limits, roles of idling swapped
    cfg_write(arke_pkg::CFG_WNOISE, 36'h1_0000_0000);
    cfg_write(arke_pkg::CFG_RNOISE, 36'd0);
    cfg_write(arke_pkg::CFG_MNOISE, 36'd0);
    cfg_write(arke_pkg::CFG_WLIM, 36'd6553600);
    cfg_write(arke_pkg::CFG_RINIT, 36'd32768);
    src_idle = 80;
    snk_idle = 31;
    add_beat('0, '0, '0, '0);
    add_beat(23'd6553600, 24'sd6553600, 24'sd6553600, '0);
    add_random(440);
    drain();

    // phase 2: other extremes, no idling
    cfg_write(arke_pkg::CFG_WNOISE, 36'd0);
    cfg_write(arke_pkg::CFG_RNOISE, 36'h1_0000_0000);
    cfg_write(arke_pkg::CFG_MNOISE, 36'd42949672960);
    cfg_write(arke_pkg::CFG_WLIM, 36'd0);
    cfg_write(arke_pkg::CFG_RINIT, 36'h1FFFF);
    src_idle = 0;
    snk_idle = 0;
    add_random(440);
    drain();

    // phase 3: all-ones register values and a low ratio start
    cfg_write(arke_pkg::CFG_WNOISE, 36'h1_FFFF_FFFF);
    cfg_write(arke_pkg::CFG_RNOISE, 36'h1_FFFF_FFFF);
    cfg_write(arke_pkg::CFG_MNOISE, 36'hF_FFFF_FFFF);
    cfg_write(arke_pkg::CFG_WLIM, 36'h7F_FFFF);
    cfg_write(arke_pkg::CFG_RINIT, 36'd0);
    add_random(440);
    drain();

    $display("covered %0d estimate beats (%0d corrected) over four register settings",
             results_seen, updates_seen);
    $display("with swapped sender/receiver stalls and a stall-free stretch");
    if (mismatches == 0 && est_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, est_q.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
